/* hdl/wma_pkg.sv */
// ---------------------------------------------------------------------------
// wma_pkg
// shared types and constants for the weighted moving average filter
// ---------------------------------------------------------------------------
`default_nettype none

package wma_pkg;

  localparam int unsigned Channels  = 10;
  localparam int unsigned MaxWindow = 16;
  localparam int unsigned ChanWidth = 4;
  localparam int unsigned SampWidth = 16;
  localparam int unsigned WinWidth  = 5;
  localparam int unsigned WsumWidth = 24;
  localparam int unsigned PsumWidth = 21;
  localparam int unsigned DivWidth  = 8;
  localparam logic [WinWidth-1:0] WinReset = 5'd10;

  typedef struct packed {
    logic [ChanWidth-1:0]        channel;
    logic signed [SampWidth-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [ChanWidth-1:0]        channel_out;
    logic signed [SampWidth-1:0] average;
    logic                        window_full;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_OUTPUT
  } wma_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic read;
    logic update;
    logic div_step;
    logic clear;
  } wma_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic valid_chan;
    logic div_done;
  } wma_stat_t;

endpackage

`default_nettype wire

/* hdl/wma_datapath.sv */
// ---------------------------------------------------------------------------
// wma_datapath
// per-channel sums, sample ring memory and restoring divider
// ---------------------------------------------------------------------------
`default_nettype none

module wma_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire wma_pkg::wma_cmd_t  cmd_i,
  output wma_pkg::wma_stat_t      stat_o,
  input  wire wma_pkg::in_item_t  item_i,
  input  wire logic [wma_pkg::WinWidth-1:0] win_i,
  output wma_pkg::out_item_t      result_o
);
  import wma_pkg::*;

  localparam int unsigned PtrW  = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned ChIdxW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned Depth = Channels * MaxWindow;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = WsumWidth + 1;

  logic signed [SampWidth-1:0] ring_mem [Depth];
  logic signed [SampWidth-1:0] oldest_q;

  logic signed [WsumWidth-1:0] wsum_q [Channels];
  logic signed [PsumWidth-1:0] psum_q [Channels];
  logic [WinWidth-1:0]         fill_q [Channels];
  logic [PtrW-1:0]             ptr_q  [Channels];

  logic [ChanWidth-1:0]        chan_q;
  logic signed [SampWidth-1:0] samp_q;
  logic [WinWidth-1:0]         n_q;
  logic                        full_q;

  logic [ChIdxW-1:0] ci;
  logic [WinWidth-1:0] n_eff;
  logic [PtrW:0] p_cur;
  logic [AddrW-1:0] addr;
  logic [WinWidth-1:0] fill_nx;
  logic signed [WsumWidth-1:0] wsum_nx;
  logic signed [PsumWidth-1:0] psum_nx;
  logic [PtrW:0] p_nx;
  logic [DivWidth-1:0] divisor;
  logic signed [WsumWidth-1:0] samp_ext;
  logic signed [WsumWidth-1:0] weight;
  logic [2*WinWidth-1:0] div_prod;

  // divider state
  logic [WsumWidth-1:0] quo_q;
  logic [WsumWidth:0]   rem_q;
  logic [DivWidth-1:0]  dvs_q;
  logic                 neg_q;
  logic [4:0]           cnt_q;
  logic [WsumWidth:0]   rem_sh;

  assign ci = chan_q[ChIdxW-1:0];

  always_comb begin
    n_eff = win_i;
    if (n_eff == '0) n_eff = WinWidth'(1);
    if (n_eff > WinWidth'(MaxWindow)) n_eff = WinWidth'(MaxWindow);
  end

  always_comb begin
    p_cur = {1'b0, ptr_q[ci]};
    if (p_cur >= (PtrW+1)'(n_q)) p_cur = '0;
    addr = AddrW'(ci * MaxWindow + p_cur);
    p_nx = p_cur + 1'b1;
    if (p_nx >= (PtrW+1)'(n_q)) p_nx = '0;
    samp_ext = WsumWidth'(samp_q);
    if (fill_q[ci] < n_q) begin
      fill_nx = fill_q[ci] + 1'b1;
      weight  = $signed(WsumWidth'(fill_nx));
      wsum_nx = wsum_q[ci] + weight * samp_ext;
      psum_nx = psum_q[ci] + PsumWidth'(samp_q);
    end else begin
      fill_nx = n_q;
      weight  = $signed(WsumWidth'(n_q));
      wsum_nx = wsum_q[ci] + weight * samp_ext - WsumWidth'(psum_q[ci]);
      psum_nx = psum_q[ci] + PsumWidth'(samp_q) - PsumWidth'(oldest_q);
    end
    div_prod = (2*WinWidth)'(fill_nx) * (2*WinWidth)'(fill_nx + 1'b1);
    divisor  = DivWidth'(div_prod >> 1);
  end

  assign stat_o.valid_chan = (item_i.channel < ChanWidth'(Channels));
  assign stat_o.div_done   = (cnt_q == 5'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      chan_q <= item_i.channel;
      samp_q <= item_i.sample;
      n_q    <= n_eff;
    end
    if (cmd_i.read) oldest_q <= ring_mem[addr];
    if (cmd_i.update) ring_mem[addr] <= samp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        wsum_q[i] <= '0;
        psum_q[i] <= '0;
        fill_q[i] <= '0;
        ptr_q[i]  <= '0;
      end
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      for (int i = 0; i < Channels; i++) begin
        wsum_q[i] <= '0;
        psum_q[i] <= '0;
        fill_q[i] <= '0;
        ptr_q[i]  <= '0;
      end
    end else if (cmd_i.update) begin
      wsum_q[ci] <= wsum_nx;
      psum_q[ci] <= psum_nx;
      fill_q[ci] <= fill_nx;
      ptr_q[ci]  <= p_nx[PtrW-1:0];
      cnt_q      <= 5'(WsumWidth);
    end else if (cmd_i.div_step && cnt_q != 5'd0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // restoring divider on the magnitude, one quotient bit a cycle
  assign rem_sh = {rem_q[WsumWidth-1:0], quo_q[WsumWidth-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      neg_q  <= wsum_nx[WsumWidth-1];
      quo_q  <= wsum_nx[WsumWidth-1] ? WsumWidth'(-wsum_nx) : wsum_nx;
      rem_q  <= '0;
      dvs_q  <= divisor;
      full_q <= (fill_nx >= n_q);
    end else if (cmd_i.div_step && cnt_q != 5'd0) begin
      if (rem_sh >= CntW'(dvs_q)) begin
        rem_q <= rem_sh - CntW'(dvs_q);
        quo_q <= {quo_q[WsumWidth-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[WsumWidth-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    result_o.channel_out = chan_q;
    result_o.average     = neg_q ? SampWidth'(-quo_q) : SampWidth'(quo_q);
    result_o.window_full = full_q;
  end

endmodule

`default_nettype wire

/* hdl/wma_ctrl.sv */
// ---------------------------------------------------------------------------
// wma_ctrl
// sequencer for one transaction: read, update, divide, hand off
// ---------------------------------------------------------------------------
`default_nettype none

module wma_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire logic              cfg_we_i,
  input  wire wma_pkg::wma_stat_t stat_i,
  output wma_pkg::wma_cmd_t      cmd_o
);
  import wma_pkg::*;

  wma_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o.clear = cfg_we_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.valid_chan) state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/weighted_moving_average_filter_core.sv */
// ---------------------------------------------------------------------------
// weighted_moving_average_filter_core
// multi-channel linearly weighted moving average
// ---------------------------------------------------------------------------
// Each transaction carries a channel number and a signed sample; the block
// returns the linearly weighted average over that channel's last N samples
// (newest weight N), quotient truncated toward zero, with window_full set
// once N samples are held. Channels at or above Channels give no result.
// The result is offered after a ring read, a sum update, a 24-step
// restoring divider and a check that the divider has finished. The next
// sample is accepted in the cycle after the result has been taken, so
// transactions never overlap; output stalls hold the result until taken.
// Writing window_length clears every channel's sums and fill count.
`default_nettype none

module weighted_moving_average_filter_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire wma_pkg::in_item_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output wma_pkg::out_item_t              out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [wma_pkg::WinWidth-1:0] cfg_wdata_i
);
  import wma_pkg::*;

  logic [WinWidth-1:0] win_q;
  wma_cmd_t  cmd;
  wma_stat_t stat;

  // window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       win_q <= WinReset;
    else if (cfg_we_i) win_q <= cfg_wdata_i;
  end

  wma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wma_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .item_i   (in_data_i),
    .win_i    (win_q),
    .result_o (out_data_o)
  );

`ifndef SYNTHESIS
  // never take a new transaction while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open with result pending");
  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
`endif

endmodule

`default_nettype wire
